// ----- sv/fwip_pkg.sv -----
`default_nettype none

package fwip_pkg;

  // fixed field widths
  localparam int COUNT_WIDTH = 12;
  localparam int TICK_MS     = 50;
  localparam int NUM_LANES   = 4;
  localparam int LANE_W      = $clog2(NUM_LANES);
  localparam int TGT_W       = 17;
  localparam int DIST_W      = 24;
  localparam int DUTY_W      = 16;
  localparam int ERR_W       = 20;
  localparam int TRAV_W      = 32;
  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 2;

  localparam int IN_TDATA_W  = ((NUM_LANES * COUNT_WIDTH + 7) / 8) * 8;
  localparam int OUT_USED_W  = NUM_LANES * DUTY_W + DIST_W + 1;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  localparam logic [TGT_W-1:0] TARGET_RESET = 17'd22938;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_TARGET  = 2'd0,
    REG_RIGHT_TARGET = 2'd1,
    REG_TARGET_DIST  = 2'd2
  } cfg_reg_e;

  localparam logic [LANE_W-1:0] LANE_LF = 2'd0;
  localparam logic [LANE_W-1:0] LANE_LB = 2'd1;
  localparam logic [LANE_W-1:0] LANE_RF = 2'd2;
  localparam logic [LANE_W-1:0] LANE_RB = 2'd3;

  // pipeline stages
  localparam int ST_IN    = 0;
  localparam int ST_MUL   = 1;
  localparam int ST_ERR   = 2;
  localparam int ST_PID   = 3;
  localparam int ST_SUM   = 4;
  localparam int ST_DIV   = 5;
  localparam int ST_OUT   = 6;
  localparam int N_STAGES = ST_OUT + 1;

  typedef struct packed {
    logic [N_STAGES-1:0] load;
    logic [N_STAGES-1:0] clr;
  } pipe_ctl_t;

  // speed: (n * num + half) / den, reduced by a common factor of 128
  localparam longint unsigned SPD_NUM  = 64'd26869760 / 64'd128;
  localparam longint unsigned SPD_DEN  = (64'd80640 * TICK_MS) / 64'd128;
  localparam longint unsigned SPD_HALF = SPD_DEN / 2;
  localparam longint unsigned SPD_NMAX = 2 * ((64'd1 << COUNT_WIDTH) - 1);
  localparam int SPD_N_W = COUNT_WIDTH + 1;
  localparam int SPD_X_W = $clog2(SPD_NMAX * SPD_NUM + SPD_HALF + 1);
  localparam int SPD_D_W = $clog2(SPD_DEN + 1);
  localparam int SPD_SH  = SPD_X_W + SPD_D_W;
  localparam longint unsigned SPD_RCP = ((64'd1 << SPD_SH) + SPD_DEN - 1) / SPD_DEN;
  localparam int SPD_R_W = $clog2(SPD_RCP + 1);
  localparam int SPD_P_W = SPD_X_W + SPD_R_W;
  localparam int SPD_W   = SPD_P_W - SPD_SH;

  localparam int ERR_HI = (1 << (ERR_W - 1)) - 1;
  localparam int ERR_LO = -(1 << (ERR_W - 1));

  // pid: c1*e1 - c2*e2 + c3*e3, gains in thousandths
  localparam int KD_GAIN   = 600;
  localparam int COEF_W    = 13;
  localparam int PROD_W    = ERR_W + COEF_W;
  localparam int PID_W     = PROD_W + 3;
  localparam int PID_BIAS  = 500;
  localparam int DIV_DROP  = 3;
  localparam longint unsigned DIV_OFF   = 64'd1000 << 22;
  localparam longint unsigned DIV_OFF_Q = DIV_OFF / 64'd1000;
  localparam logic [PID_W-1:0] PID_OFF  = PID_W'(DIV_OFF + PID_BIAS);
  localparam longint unsigned DIV_DEN   = 64'd1000 >> DIV_DROP;
  localparam int DIV_Z_W = $clog2(2 * DIV_OFF) - DIV_DROP;
  localparam int DIV_D_W = $clog2(DIV_DEN + 1);
  localparam int DIV_SH  = DIV_Z_W + DIV_D_W;
  localparam longint unsigned DIV_RCP = ((64'd1 << DIV_SH) + DIV_DEN - 1) / DIV_DEN;
  localparam int DIV_R_W = $clog2(DIV_RCP + 1);
  localparam int DIV_P_W = DIV_Z_W + DIV_R_W;
  localparam int DIV_Q_W = DIV_P_W - DIV_SH;
  localparam int DSUM_W  = DIV_Q_W + 2;

  localparam logic [DUTY_W-1:0] DUTY_MIN = 16'd13107;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 16'd58982;

  // distance increment: sum*quo + (sum*rem + bias) / den
  localparam int SUM_W = COUNT_WIDTH + $clog2(NUM_LANES);
  localparam longint unsigned SUM_MAX   = NUM_LANES * ((64'd1 << COUNT_WIDTH) - 1);
  localparam longint unsigned DIST_MUL  = 64'd687865856 / 64'd2048;
  localparam longint unsigned DIST_DEN  = 64'd16128000 / 64'd2048;
  localparam longint unsigned DIST_BIAS = DIST_DEN / 2;
  localparam longint unsigned DIST_QUO  = DIST_MUL / DIST_DEN;
  localparam longint unsigned DIST_REM  = DIST_MUL % DIST_DEN;
  localparam int DIST_HI_W = $clog2(SUM_MAX * DIST_QUO + 1);
  localparam int DIST_X_W  = $clog2(SUM_MAX * DIST_REM + DIST_BIAS + 1);
  localparam int DIST_D_W  = $clog2(DIST_DEN + 1);
  localparam int DIST_SH   = DIST_X_W + DIST_D_W;
  localparam longint unsigned DIST_RCP = ((64'd1 << DIST_SH) + DIST_DEN - 1) / DIST_DEN;
  localparam int DIST_R_W  = $clog2(DIST_RCP + 1);
  localparam int DIST_P_W  = DIST_X_W + DIST_R_W;
  localparam int DIST_Q_W  = DIST_P_W - DIST_SH;
  localparam int INC_W     = ((DIST_HI_W > DIST_Q_W) ? DIST_HI_W : DIST_Q_W) + 1;
  localparam int DIST_SHIFT = TRAV_W - DIST_W;

  function automatic int gain_p(input logic [LANE_W-1:0] lane);
    int g;
    case (lane)
      LANE_LF: g = 920;
      LANE_LB: g = 890;
      LANE_RF: g = 880;
      LANE_RB: g = 890;
      default: g = 890;
    endcase
    return g;
  endfunction

  function automatic int gain_i(input logic [LANE_W-1:0] lane);
    int g;
    case (lane)
      LANE_LF: g = 272;
      LANE_LB: g = 316;
      LANE_RF: g = 298;
      LANE_RB: g = 262;
      default: g = 262;
    endcase
    return g;
  endfunction

  function automatic logic signed [COEF_W-1:0] pid_c1(input logic [LANE_W-1:0] lane);
    return COEF_W'(gain_p(lane) + gain_i(lane) + KD_GAIN);
  endfunction

  function automatic logic signed [COEF_W-1:0] pid_c2(input logic [LANE_W-1:0] lane);
    return COEF_W'(gain_p(lane) + 2 * KD_GAIN);
  endfunction

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [31:0] v);
    logic signed [ERR_W-1:0] r;
    if (v > ERR_HI) begin
      r = ERR_W'(ERR_HI);
    end else if (v < ERR_LO) begin
      r = ERR_W'(ERR_LO);
    end else begin
      r = v[ERR_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/fwip_lane.sv -----
`default_nettype none

module fwip_lane
  import fwip_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [LANE_W-1:0]      lane_i,
  input  pipe_ctl_t              ctl_i,
  input  logic [COUNT_WIDTH-1:0] count_i,
  input  logic [TGT_W-1:0]       target_i,
  output logic [DUTY_W-1:0]      duty_o
);

  logic [COUNT_WIDTH-1:0]   prev_q, prev_d;
  logic [SPD_N_W-1:0]       n_sum;
  logic [SPD_X_W-1:0]       x_q, x_d;
  logic [SPD_P_W-1:0]       sp_prod_q;
  logic [SPD_W-1:0]         speed;
  logic signed [31:0]       diff;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [ERR_W-1:0]  last_err_q, last_err_d;
  logic signed [ERR_W-1:0]  prev_err_q, prev_err_d;
  logic signed [COEF_W-1:0] c1, c2, c3;
  logic signed [PROD_W-1:0] p1_q, p2_q, p3_q;
  logic [PID_W-1:0]         pid_sum;
  logic [DIV_Z_W-1:0]       z_q;
  logic [DIV_P_W-1:0]       dv_prod_q;
  logic [DIV_Q_W-1:0]       quot;
  logic signed [DSUM_W-1:0] duty_sum;
  logic [DUTY_W-1:0]        duty_q, duty_d;

  assign c1 = pid_c1(lane_i);
  assign c2 = pid_c2(lane_i);
  assign c3 = COEF_W'(KD_GAIN);

  // speed numerator from this and the last count
  assign n_sum  = SPD_N_W'(count_i) + SPD_N_W'(prev_q);
  assign x_d    = SPD_X_W'(n_sum * SPD_NUM + SPD_HALF);
  assign prev_d = ctl_i.clr[ST_IN] ? '0 : count_i;

  assign speed = sp_prod_q[SPD_P_W-1:SPD_SH];
  assign diff  = $signed(32'(target_i)) - $signed(32'(speed));

  always_comb begin
    if (ctl_i.clr[ST_PID]) begin
      last_err_d = '0;
      prev_err_d = '0;
    end else begin
      last_err_d = err_q;
      prev_err_d = last_err_q;
    end
  end

  // biased so the floor division sees a positive value
  assign pid_sum = PID_W'(p1_q) - PID_W'(p2_q) + PID_W'(p3_q) + PID_OFF;

  assign quot     = dv_prod_q[DIV_P_W-1:DIV_SH];
  assign duty_sum = $signed(DSUM_W'(duty_q)) + $signed(DSUM_W'(quot))
                    - $signed(DSUM_W'(DIV_OFF_Q));

  always_comb begin
    if (ctl_i.clr[ST_OUT]) begin
      duty_d = '0;
    end else if (duty_sum > $signed(DSUM_W'(DUTY_MAX))) begin
      duty_d = DUTY_MAX;
    end else if (duty_sum < $signed(DSUM_W'(DUTY_MIN))) begin
      duty_d = DUTY_MIN;
    end else begin
      duty_d = duty_sum[DUTY_W-1:0];
    end
  end

  // per-wheel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      last_err_q <= '0;
      prev_err_q <= '0;
      duty_q     <= '0;
    end else begin
      if (ctl_i.load[ST_IN]) begin
        prev_q <= prev_d;
      end
      if (ctl_i.load[ST_PID]) begin
        last_err_q <= last_err_d;
        prev_err_q <= prev_err_d;
      end
      if (ctl_i.load[ST_OUT]) begin
        duty_q <= duty_d;
      end
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (ctl_i.load[ST_IN]) begin
      x_q <= x_d;
    end
    if (ctl_i.load[ST_MUL]) begin
      sp_prod_q <= SPD_P_W'(x_q * SPD_RCP);
    end
    if (ctl_i.load[ST_ERR]) begin
      err_q <= sat_err(diff);
    end
    if (ctl_i.load[ST_PID]) begin
      p1_q <= PROD_W'(c1) * PROD_W'(err_q);
      p2_q <= PROD_W'(c2) * PROD_W'(last_err_q);
      p3_q <= PROD_W'(c3) * PROD_W'(prev_err_q);
    end
    if (ctl_i.load[ST_SUM]) begin
      z_q <= pid_sum[DIV_Z_W+DIV_DROP-1:DIV_DROP];
    end
    if (ctl_i.load[ST_DIV]) begin
      dv_prod_q <= DIV_P_W'(z_q * DIV_RCP);
    end
  end

  assign duty_o = duty_q;

endmodule

`default_nettype wire

// ----- sv/fwip_dist.sv -----
`default_nettype none

module fwip_dist
  import fwip_pkg::*;
(
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pipe_ctl_t                            ctl_i,
  input  logic [NUM_LANES-1:0][COUNT_WIDTH-1:0] counts_i,
  input  logic [DIST_W-1:0]                    target_i,
  output logic [DIST_W-1:0]                    dist_o,
  output logic                                 reached_o
);

  logic [SUM_W-1:0]     sum;
  logic [DIST_HI_W-1:0] hi_q, hi1_q;
  logic [DIST_X_W-1:0]  dx_q;
  logic [DIST_P_W-1:0]  dprod_q;
  logic [INC_W-1:0]     inc;
  logic [TRAV_W:0]      total;
  logic [TRAV_W-1:0]    trav_q, trav_d;
  logic [DIST_W-1:0]    dist_new;
  logic [DIST_W-1:0]    dist_pipe_q [N_STAGES-1:ST_ERR];
  logic                 reach_pipe_q [N_STAGES-1:ST_ERR];

  // merge the lane counts
  always_comb begin
    sum = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      sum = sum + SUM_W'(counts_i[k]);
    end
  end

  assign inc   = INC_W'(hi1_q) + INC_W'(dprod_q[DIST_P_W-1:DIST_SH]);
  assign total = (TRAV_W + 1)'(trav_q) + (TRAV_W + 1)'(inc);

  always_comb begin
    if (ctl_i.clr[ST_ERR]) begin
      trav_d = '0;
    end else if (total[TRAV_W]) begin
      trav_d = '1;
    end else begin
      trav_d = total[TRAV_W-1:0];
    end
  end

  assign dist_new = trav_d[TRAV_W-1:DIST_SHIFT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trav_q <= '0;
    end else if (ctl_i.load[ST_ERR]) begin
      trav_q <= trav_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[ST_IN]) begin
      hi_q <= DIST_HI_W'(sum * DIST_QUO);
      dx_q <= DIST_X_W'(sum * DIST_REM + DIST_BIAS);
    end
    if (ctl_i.load[ST_MUL]) begin
      hi1_q   <= hi_q;
      dprod_q <= DIST_P_W'(dx_q * DIST_RCP);
    end
    if (ctl_i.load[ST_ERR]) begin
      dist_pipe_q[ST_ERR]  <= dist_new;
      reach_pipe_q[ST_ERR] <= (dist_new >= target_i);
    end
    for (int k = ST_ERR + 1; k < N_STAGES; k++) begin
      if (ctl_i.load[k]) begin
        dist_pipe_q[k]  <= dist_pipe_q[k-1];
        reach_pipe_q[k] <= reach_pipe_q[k-1];
      end
    end
  end

  assign dist_o    = dist_pipe_q[ST_OUT];
  assign reached_o = reach_pipe_q[ST_OUT];

endmodule

`default_nettype wire

// ----- sv/four_wheel_incremental_pid.sv -----
// four-wheel incremental pid speed controller
//
// input stream: one beat per control tick. tuser is the operation (0 tick,
// 1 restart), tdata carries the four 12-bit encoder counts. every accepted
// beat gives exactly one output beat with the four duties, the travelled
// distance and the reached flag.
// throughput: one beat per cycle while m_axis_tready stays high. each of the seven
// pipeline stages owns the wheel state it reads, so consecutive beats never
// wait on each other; the lane pipeline has seven stages (two multiplier
// stages for speed and for the divide by 1000).
// configuration: plain write port, index 0 left target, 1 right target,
// 2 target distance; other indices are ignored. write only while idle.
// reset: targets return to 22938, target distance to 0, all wheel state and
// the distance clear, pipeline empties and s_axis_tready comes up high.
// stall: when m_axis_tready is low the output beat holds; upstream stages keep
// filling bubbles and s_axis_tready drops only once the pipeline is full.

`default_nettype none

module four_wheel_incremental_pid
  import fwip_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // slave side
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // lf, lb, rf, rb counts
  input  logic                   s_axis_tuser,   // op
  // master side
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // lf, lb, rf, rb duty, distance, reached
  // configuration
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  logic [TGT_W-1:0]  left_target_q, right_target_q;
  logic [DIST_W-1:0] target_dist_q;

  logic [N_STAGES-1:0] vld_q, op_q;
  logic [N_STAGES-1:0] en, in_vld, in_op;
  pipe_ctl_t           ctl;

  logic [NUM_LANES-1:0][COUNT_WIDTH-1:0] counts;
  logic [NUM_LANES-1:0][DUTY_W-1:0]      duty;
  logic [DIST_W-1:0]                     distance;
  logic                                  reached;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_target_q  <= TARGET_RESET;
      right_target_q <= TARGET_RESET;
      target_dist_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEFT_TARGET:  left_target_q  <= cfg_data_i[TGT_W-1:0];
        REG_RIGHT_TARGET: right_target_q <= cfg_data_i[TGT_W-1:0];
        REG_TARGET_DIST:  target_dist_q  <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables ripple back from the output
  always_comb begin
    en[N_STAGES-1] = !vld_q[N_STAGES-1] || m_axis_tready;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    in_vld[0] = s_axis_tvalid;
    in_op[0]  = s_axis_tuser;
    for (int k = 1; k < N_STAGES; k++) begin
      in_vld[k] = vld_q[k-1];
      in_op[k]  = op_q[k-1];
    end
    ctl.load = en & in_vld;
    ctl.clr  = en & in_vld & in_op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      op_q  <= '0;
    end else begin
      for (int k = 0; k < N_STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= in_vld[k];
          op_q[k]  <= in_op[k];
        end
      end
    end
  end

  assign counts = s_axis_tdata[NUM_LANES*COUNT_WIDTH-1:0];

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    fwip_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .lane_i   (LANE_W'(g)),
      .ctl_i    (ctl),
      .count_i  (counts[g]),
      .target_i ((g < NUM_LANES / 2) ? left_target_q : right_target_q),
      .duty_o   (duty[g])
    );
  end

  fwip_dist u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .counts_i  (counts),
    .target_i  (target_dist_q),
    .dist_o    (distance),
    .reached_o (reached)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[N_STAGES-1];
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, reached, distance, duty};

endmodule

`default_nettype wire

// ----- sv/fwip_checker.sv -----
`default_nettype none

module fwip_checker
  import fwip_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  function automatic logic duty_ok(input logic [DUTY_W-1:0] d);
    return (d == '0) || ((d >= DUTY_MIN) && (d <= DUTY_MAX));
  endfunction

  // output beat held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // pipeline can only be full when a beat waits at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // duties are zero after restart or inside the clamp window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> duty_ok(m_axis_tdata[DUTY_W-1:0])
                   && duty_ok(m_axis_tdata[2*DUTY_W-1:DUTY_W])
                   && duty_ok(m_axis_tdata[3*DUTY_W-1:2*DUTY_W])
                   && duty_ok(m_axis_tdata[4*DUTY_W-1:3*DUTY_W]))
    else $error("duty outside clamp range");

  // after an accepted input beat, input stays ready or a beat waits at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> s_axis_tready || m_axis_tvalid)
    else $error("input blocked with no beat at the output");

endmodule

bind four_wheel_incremental_pid fwip_checker u_fwip_checker (.*);

`default_nettype wire

// ----- verif/tb_four_wheel_incremental_pid.sv -----
`default_nettype none

module tb_four_wheel_incremental_pid;
  timeunit 1ns;
  timeprecision 1ps;

  import fwip_pkg::*;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_RESTART = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam longint SPD_SCALE    = 26869760;
  localparam longint SPD_DIV      = 80640 * TICK_MS;
  localparam longint TRAVEL_SCALE = 687865856;
  localparam longint TRAVEL_DIV   = 16128000;
  localparam longint TRAVEL_TOP   = 64'h0000_0000_FFFF_FFFF;
  localparam longint DUTY_FLOOR   = 13107;
  localparam longint DUTY_CEIL    = 58982;
  localparam longint ERR_TOP      = 524287;
  localparam longint ERR_BOTTOM   = -524288;
  localparam longint D_GAIN       = 600;

  localparam logic [TGT_W-1:0]       TGT_DEFAULT = 17'd22938;
  localparam logic [TGT_W-1:0]       TGT_TOP     = '1;
  localparam logic [DIST_W-1:0]      GOAL_TOP    = '1;
  localparam logic [DIST_W-1:0]      GOAL_MID    = 24'd300000;
  localparam logic [COUNT_WIDTH-1:0] COUNT_TOP   = '1;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RUN_TICKS    = 200;

  typedef logic [NUM_LANES-1:0][COUNT_WIDTH-1:0] counts_t;

  typedef struct packed {
    logic             reached;
    logic [DIST_W-1:0] distance;
    logic [NUM_LANES-1:0][DUTY_W-1:0] duty;
  } duty_report_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_W-1:0]       cfg_data_i    = '0;

  // controller model
  logic [TGT_W-1:0]       left_goal  = TGT_DEFAULT;
  logic [TGT_W-1:0]       right_goal = TGT_DEFAULT;
  logic [DIST_W-1:0]      dist_goal  = '0;
  logic [COUNT_WIDTH-1:0] prev_cnt [NUM_LANES];
  longint                 err_last [NUM_LANES];
  longint                 err_prev [NUM_LANES];
  longint                 duty_acc [NUM_LANES];
  longint                 travelled;

  duty_report_t duty_report_q [$];

  int n_ticks        = 0;
  int n_restarts     = 0;
  int n_checked      = 0;
  int n_errors       = 0;
  int n_reg_writes   = 0;
  int stuck_cycles   = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;

  logic    beat_full  = 1'b0;
  logic    beat_shown = 1'b0;
  logic    beat_op    = 1'b0;
  counts_t beat_cnt   = '0;

  four_wheel_incremental_pid u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // lf, lb, rf, rb counts
    .s_axis_tuser  (s_axis_tuser),   // op
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // lf, lb, rf, rb duty, distance, reached
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic longint wheel_kp(input int w);
    case (w)
      0:       return 920;
      1:       return 890;
      2:       return 880;
      default: return 890;
    endcase
  endfunction

  function automatic longint wheel_ki(input int w);
    case (w)
      0:       return 272;
      1:       return 316;
      2:       return 298;
      default: return 262;
    endcase
  endfunction

  function automatic void clear_wheels();
    for (int w = 0; w < NUM_LANES; w++) begin
      prev_cnt[w] = '0;
      err_last[w] = 0;
      err_prev[w] = 0;
      duty_acc[w] = 0;
    end
    travelled = 0;
  endfunction

  task automatic step_wheels(input logic op, input counts_t cnt, output duty_report_t rep);
    longint spd, goal, e1, e2, e3, acc, step, duty, csum, total;
    csum = 0;
    if (op == OP_RESTART) begin
      clear_wheels();
    end else begin
      for (int w = 0; w < NUM_LANES; w++) begin
        spd = ((longint'(cnt[w]) + longint'(prev_cnt[w])) * SPD_SCALE + SPD_DIV / 2) / SPD_DIV;
        goal = (w < 2) ? longint'(left_goal) : longint'(right_goal);
        csum += longint'(cnt[w]);
        prev_cnt[w] = cnt[w];
        e1 = goal - spd;
        if (e1 > ERR_TOP) e1 = ERR_TOP;
        if (e1 < ERR_BOTTOM) e1 = ERR_BOTTOM;
        e2 = err_last[w];
        e3 = err_prev[w];
        acc = wheel_kp(w) * (e1 - e2) + wheel_ki(w) * e1 + D_GAIN * (e1 - 2 * e2 + e3) + 500;
        // round towards minus infinity
        step = (acc >= 0) ? acc / 1000 : -((-acc + 999) / 1000);
        duty = duty_acc[w] + step;
        if (duty > DUTY_CEIL) duty = DUTY_CEIL;
        if (duty < DUTY_FLOOR) duty = DUTY_FLOOR;
        duty_acc[w] = duty;
        err_prev[w] = err_last[w];
        err_last[w] = e1;
      end
      total = travelled + (csum * TRAVEL_SCALE + TRAVEL_DIV / 2) / TRAVEL_DIV;
      travelled = (total > TRAVEL_TOP) ? TRAVEL_TOP : total;
    end
    for (int w = 0; w < NUM_LANES; w++) begin
      rep.duty[w] = duty_acc[w][DUTY_W-1:0];
    end
    rep.distance = travelled[31:8];
    rep.reached  = (travelled[31:8] >= dist_goal);
  endtask

  task automatic check_report(input duty_report_t exp_rep, input duty_report_t act_rep);
    for (int w = 0; w < NUM_LANES; w++) begin
      if (act_rep.duty[w] !== exp_rep.duty[w]) begin
        $display("%0t: wheel %0d duty expected %0d actual %0d", $time, w,
                 exp_rep.duty[w], act_rep.duty[w]);
        n_errors++;
      end
    end
    if (act_rep.distance !== exp_rep.distance) begin
      $display("%0t: distance expected %0d actual %0d", $time,
               exp_rep.distance, act_rep.distance);
      n_errors++;
    end
    if (act_rep.reached !== exp_rep.reached) begin
      $display("%0t: reached expected %0b actual %0b", $time,
               exp_rep.reached, act_rep.reached);
      n_errors++;
    end
  endtask

  // input driver: holds a beat until it is taken
  always @(posedge clk_i) begin
    if (beat_full && (beat_shown || $urandom_range(99) >= src_idle_pct)) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= beat_cnt;
      s_axis_tuser  <= beat_op;
      beat_shown = 1'b1;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // output ready, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // handshakes are sampled mid-cycle, the beat moves at the next rising edge
  always @(negedge clk_i) begin : monitor
    duty_report_t exp_rep;
    duty_report_t act_rep;
    if (s_axis_tvalid && s_axis_tready) begin
      step_wheels(s_axis_tuser, s_axis_tdata, exp_rep);
      duty_report_q.push_back(exp_rep);
      if (s_axis_tuser == OP_RESTART) begin
        n_restarts++;
      end else begin
        n_ticks++;
      end
      beat_full  = 1'b0;
      beat_shown = 1'b0;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      act_rep = m_axis_tdata[OUT_USED_W-1:0];
      if (duty_report_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none actual %h",
                 $time, act_rep);
        n_errors++;
      end else begin
        exp_rep = duty_report_q.pop_front();
        check_report(exp_rep, act_rep);
        n_checked++;
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
               $time, stuck_cycles, duty_report_q.size());
      $display("four_wheel_incremental_pid test failed");
      $finish;
    end
  end

  task automatic send_beat(input logic op, input counts_t cnt);
    beat_op   = op;
    beat_cnt  = cnt;
    beat_full = 1'b1;
    wait (!beat_full);
  endtask

  task automatic drain();
    while (duty_report_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_LEFT_TARGET:  left_goal = data[TGT_W-1:0];
      REG_RIGHT_TARGET: right_goal = data[TGT_W-1:0];
      REG_TARGET_DIST:  dist_goal = data[DIST_W-1:0];
      default: ;
    endcase
    n_reg_writes++;
  endtask

  function automatic logic [COUNT_WIDTH-1:0] near_count(input logic [TGT_W-1:0] goal,
                                                        input int spread);
    longint v;
    v = longint'(goal) * SPD_DIV / SPD_SCALE / 2 + $urandom_range(2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > COUNT_TOP) v = COUNT_TOP;
    return v[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [CFG_W-1:0] random_target();
    logic [TGT_W-1:0] v;
    case ($urandom_range(7))
      0:       v = '0;
      1:       v = TGT_TOP;
      2:       v = TGT_W'($urandom_range(TGT_TOP));
      default: v = TGT_W'($urandom_range(45000, 8000));
    endcase
    // spare upper bits carry junk
    return {7'($urandom_range(127)), v};
  endfunction

  task automatic send_random_beat();
    counts_t cnt;
    int r;
    r = $urandom_range(99);
    for (int w = 0; w < NUM_LANES; w++) begin
      if (r < 60) begin
        cnt[w] = near_count((w < 2) ? left_goal : right_goal, 60);
      end else if (r < 80) begin
        cnt[w] = COUNT_WIDTH'($urandom_range(COUNT_TOP));
      end else if (r < 90) begin
        cnt[w] = COUNT_WIDTH'($urandom_range(15));
      end else begin
        case ($urandom_range(2))
          0:       cnt[w] = '0;
          1:       cnt[w] = COUNT_TOP;
          default: cnt[w] = COUNT_WIDTH'($urandom_range(COUNT_TOP));
        endcase
      end
    end
    send_beat((r < 4) ? OP_RESTART : OP_TICK, cnt);
  endtask

  task automatic test_directed();
    counts_t cnt;
    send_beat(OP_TICK, '0);
    send_beat(OP_TICK, {NUM_LANES{COUNT_TOP}});
    send_beat(OP_TICK, {NUM_LANES{12'hAAA}});
    send_beat(OP_TICK, {NUM_LANES{12'h555}});
    for (int w = 0; w < NUM_LANES; w++) begin
      cnt = '0;
      cnt[w] = COUNT_TOP;
      send_beat(OP_TICK, cnt);
    end
    send_beat(OP_RESTART, '0);
    // restart ignores whatever counts come with it
    send_beat(OP_RESTART, {NUM_LANES{COUNT_TOP}});
    repeat (6) begin
      send_beat(OP_TICK, {NUM_LANES{12'd1721}});
    end
    drain();
    write_reg(REG_TARGET_DIST, 24'd1000);
    send_beat(OP_RESTART, '0);
    repeat (4) begin
      send_beat(OP_TICK, {NUM_LANES{COUNT_TOP}});
    end
  endtask

  task automatic test_register_extremes();
    drain();
    write_reg(REG_LEFT_TARGET, '0);
    write_reg(REG_RIGHT_TARGET, CFG_W'(TGT_TOP));
    write_reg(REG_TARGET_DIST, GOAL_TOP);
    send_beat(OP_RESTART, '0);
    repeat (2) send_beat(OP_TICK, '0);
    repeat (2) send_beat(OP_TICK, {NUM_LANES{COUNT_TOP}});
    repeat (2) send_random_beat();
    drain();
    write_reg(REG_LEFT_TARGET, CFG_W'(TGT_TOP));
    write_reg(REG_RIGHT_TARGET, '0);
    write_reg(REG_TARGET_DIST, '0);
    repeat (4) send_random_beat();
    drain();
    // writes to the unused index must change nothing
    write_reg(REG_SPARE, CFG_W'($urandom));
    repeat (3) send_random_beat();
    drain();
    write_reg(REG_LEFT_TARGET, CFG_W'(TGT_DEFAULT));
    write_reg(REG_RIGHT_TARGET, CFG_W'(TGT_DEFAULT));
  endtask

  task automatic test_distance_run();
    drain();
    write_reg(REG_TARGET_DIST, GOAL_MID);
    send_beat(OP_RESTART, '0);
    repeat (RUN_TICKS) begin
      send_beat(OP_TICK, {NUM_LANES{COUNT_TOP}});
    end
    send_beat(OP_RESTART, '0);
    drain();
    write_reg(REG_TARGET_DIST, '0);
  endtask

  task automatic test_backpressure();
    drain();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_request   = 64;
    repeat (24) send_random_beat();
    drain();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int beats);
    drain();
    write_reg(REG_LEFT_TARGET, random_target());
    write_reg(REG_RIGHT_TARGET, random_target());
    write_reg(REG_TARGET_DIST, ($urandom_range(9) == 0) ? GOAL_TOP :
                               CFG_W'($urandom_range(400000)));
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    for (int k = 0; k < beats; k++) begin
      send_random_beat();
      if ($urandom_range(99) == 0) drain();
    end
  endtask

  initial begin
    clear_wheels();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_distance_run();
    test_backpressure();
    test_random_traffic(0, 0, 260);
    test_random_traffic(55, 0, 260);
    test_random_traffic(0, 55, 260);
    test_random_traffic(28, 28, 260);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d control ticks and %0d restarts over %0d register writes,",
             n_ticks, n_restarts, n_reg_writes);
    $display("a full-speed run past the distance goal, a long output hold-off and %s %0d %s %0d",
             "four idle/stall mixes; results compared", n_checked, "mismatches", n_errors);
    if (n_errors == 0 && duty_report_q.size() == 0) begin
      $display("four_wheel_incremental_pid test passed");
    end else begin
      $display("four_wheel_incremental_pid test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
